// File: rtl/gst_pkg.sv
// ---------------------------------------------------------------------------
// gst_pkg
// Shared types, constants and the per-pixel sharpening function for the
// gradient sharpening block.
// ---------------------------------------------------------------------------
package gst_pkg;

   localparam int unsigned MaxWidthDefault = 2048;

   localparam logic [7:0] ThresholdReset = 8'd30;
   localparam logic [8:0] SharpOffset    = 9'd120;
   localparam logic [7:0] SharpCeil      = 8'd255;
   localparam logic [8:0] SharpLimit     = 9'd135;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_last;
      logic       frame_last;
   } result_type;

   // Up to two results per request; second_vld is set only with first_vld.
   typedef struct packed {
      logic       first_vld;
      result_type first;
      logic       second_vld;
      result_type second;
   } push_type;

   function automatic logic [7:0] sharpen(input logic [7:0] p,
                                          input logic [7:0] below,
                                          input logic [7:0] right,
                                          input logic [7:0] thr);
      logic [8:0] d_below;
      logic [8:0] d_right;
      logic [8:0] g;
      logic [8:0] boosted;
      logic [7:0] r;
      d_below = (p >= below) ? {1'b0, p - below} : {1'b0, below - p};
      d_right = (p >= right) ? {1'b0, p - right} : {1'b0, right - p};
      g       = d_below + d_right;
      boosted = g + SharpOffset;
      if (g >= SharpLimit) begin
         r = SharpCeil;
      end else if (g >= {1'b0, thr}) begin
         r = boosted[7:0];
      end else begin
         r = p;
      end
      return r;
   endfunction

endpackage

// File: rtl/gst_line_buffer.sv
// ---------------------------------------------------------------------------
// gst_line_buffer
// One-row line buffer. Read-first single port: the old value of a column is
// returned (registered) while the new pixel is written in the same cycle.
// ---------------------------------------------------------------------------
module gst_line_buffer
   import gst_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic [$clog2(MAX_WIDTH)-1:0] addr,
   input  logic [7:0]                   wdata,
   output logic [7:0]                   rdata
);

   logic [7:0] ram_ff [MAX_WIDTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rdata_ff     <= ram_ff[addr];
         ram_ff[addr] <= wdata;
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/gst_result_fifo.sv
// ---------------------------------------------------------------------------
// gst_result_fifo
// Small result queue: up to two results in a cycle, one out a cycle if ready.
// ---------------------------------------------------------------------------
module gst_result_fifo
   import gst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room,        // space for two more results
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   localparam int unsigned Depth = 4;
   localparam int unsigned PtrW  = $clog2(Depth);
   localparam int unsigned CntW  = $clog2(Depth + 1);

   result_type      q_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;
   logic [1:0]      push_cnt;

   assign pop       = out_valid && out_ready;
   assign push_cnt  = 2'(push.first_vld) + 2'(push.second_vld);
   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[rd_ptr_ff];
   assign room      = (count_ff <= CntW'(Depth - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CntW'(push_cnt) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_vld) begin
         q_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_vld) begin
         q_ff[wr_ptr_ff + PtrW'(1)] <= push.second;
      end
   end

endmodule

// File: rtl/gradient_sharpen_threshold_top.sv
// ---------------------------------------------------------------------------
// gradient_sharpen_threshold_top
// Gradient sharpening with threshold on a bottom-up raster pixel stream.
// ---------------------------------------------------------------------------
// Takes one 8-bit grey pixel per clock when ready (bottom row first, left to
// right, tlast on a row's last pixel, tuser on the frame's last pixel) and
// returns g = |p - below| + |p - right| mapped to 255 (g >= 135), g + 120
// (g >= threshold) or p. Each pixel waits for its right neighbor, so results
// lag by one pixel and a row's last pixel yields two results; missing
// neighbors (first row of a frame, last column) are replaced by p itself.
// A request is taken every cycle while stage A is free or advancing; results
// leave at one per clock when ready, through a four-entry queue, and input
// backs off only when that queue holds three or more results. A result
// enters the queue from stage A once the queue has room. The row below lives
// in a MAX_WIDTH x 8 single-port line buffer, read and written once per
// request; rows longer than MAX_WIDTH wrap in the buffer.
module gradient_sharpen_threshold_top
   import gst_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = MaxWidthDefault
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] pixel_in
   input  logic       req_tlast,   // row_end
   input  logic [0:0] req_tuser,   // [0] frame_end
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] pixel_out
   output logic       rsp_tlast,   // row_last
   output logic [0:0] rsp_tuser,   // [0] frame_last
   // threshold register
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   localparam int unsigned AddrW = $clog2(MAX_WIDTH);

   logic             accept;
   logic             row_done;
   logic             a_adv;
   logic             fifo_room;

   logic [7:0]       thr_ff, thr_in;
   logic [AddrW-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;

   // stage A: request just taken, line buffer read in flight
   logic             a_valid_ff, a_valid_in;
   logic [7:0]       a_pix_ff;
   logic             a_end_ff;
   logic             a_frame_ff;
   logic             a_first_ff;

   // pixel waiting for its right neighbor
   logic             held_valid_ff, held_valid_in;
   logic [7:0]       held_pix_ff;
   logic [7:0]       held_below_ff;

   logic [7:0]       below_rd;
   logic [7:0]       below_a;
   result_type       held_res;
   result_type       own_res;
   push_type         push;
   result_type       out_res;

   assign row_done   = req_tlast | req_tuser[0];
   assign a_adv      = a_valid_ff && fifo_room;
   assign req_tready = !a_valid_ff || a_adv;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      thr_in       = csr_wr_en ? csr_wr_data : thr_ff;
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         if (row_done) begin
            col_in       = '0;
            first_row_in = req_tuser[0];
         end else if (col_ff == AddrW'(MAX_WIDTH - 1)) begin
            col_in = '0;
         end else begin
            col_in = col_ff + AddrW'(1);
         end
      end
      a_valid_in    = accept ? 1'b1 : (a_adv ? 1'b0 : a_valid_ff);
      held_valid_in = a_adv ? !a_end_ff : held_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= ThresholdReset;
         col_ff        <= '0;
         first_row_ff  <= 1'b1;
         a_valid_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         thr_ff        <= thr_in;
         col_ff        <= col_in;
         first_row_ff  <= first_row_in;
         a_valid_ff    <= a_valid_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_pix_ff   <= req_tdata;
         a_end_ff   <= row_done;
         a_frame_ff <= req_tuser[0];
         a_first_ff <= first_row_ff;
      end
      if (a_adv && !a_end_ff) begin
         held_pix_ff   <= a_pix_ff;
         held_below_ff <= below_a;
      end
   end

   gst_line_buffer #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock (clock),
      .en    (accept),
      .addr  (col_ff),
      .wdata (req_tdata),
      .rdata (below_rd)
   );

   // first row of a frame has no row below: use the pixel itself
   assign below_a = a_first_ff ? a_pix_ff : below_rd;

   always_comb begin
      held_res.pixel      = sharpen(held_pix_ff, held_below_ff, a_pix_ff, thr_ff);
      held_res.row_last   = 1'b0;
      held_res.frame_last = 1'b0;
      own_res.pixel       = sharpen(a_pix_ff, below_a, a_pix_ff, thr_ff);
      own_res.row_last    = 1'b1;
      own_res.frame_last  = a_frame_ff;

      push.first_vld  = a_adv && (held_valid_ff || a_end_ff);
      push.first      = held_valid_ff ? held_res : own_res;
      push.second_vld = a_adv && held_valid_ff && a_end_ff;
      push.second     = own_res;
   end

   gst_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (fifo_room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata    = out_res.pixel;
   assign rsp_tlast    = out_res.row_last;
   assign rsp_tuser[0] = out_res.frame_last;

endmodule

// File: rtl/gst_checker.sv
// ---------------------------------------------------------------------------
// gst_checker
// Port-level checks for the gradient sharpening block, bound to the top.
// ---------------------------------------------------------------------------
module gst_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast)
                                     && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // reset empties the result queue
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // a result only appears in an empty queue after a request has been taken
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result appeared without a matching request");

endmodule

bind gradient_sharpen_threshold_top gst_checker u_gst_checker (.*);

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Checks gradient_sharpen_threshold_top against a cycle-free model of the
// sharpening rule. A short table of hand-checked frames runs first, then
// random frames under four idle/stall patterns with a new threshold for each.
// ---------------------------------------------------------------------------
module testbench;
   import gst_pkg::*;

   localparam int LineSlots    = MaxWidthDefault;
   localparam int NumDirected  = 17;
   localparam int SettleCycles = 8;
   localparam int PhaseItems   = 475;

   typedef struct {
      bit [7:0] pix;
      bit       rend;
      bit       fend;
      bit       typed;
      bit [7:0] exp_pix;
      bit       exp_rl;
      bit       exp_fl;
   } stim_row_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = '0;
   logic       req_tlast   = 1'b0;
   logic [0:0] req_tuser   = '0;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [0:0] rsp_tuser;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = '0;

   // model state
   bit [7:0]     line_buf [LineSlots];
   int           line_filled;     // slots 0..line_filled-1 hold a written value
   bit [7:0]     held_pix;
   bit           held_ok;
   int           col_cnt;
   bit           at_frame_top;
   bit [7:0]     thr_shadow;
   int           done_pixels;

   result_type   sharpened_q [$];
   stim_row_type dir_rows [NumDirected];
   int           mismatches;
   int           send_idle;
   int           recv_stall;
   int           items_sent;

   gradient_sharpen_threshold_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

   function automatic bit [7:0] sharpen_value(bit [7:0] p, bit [7:0] below, bit [7:0] right);
      int g;
      g = ((p > below) ? p - below : below - p) + ((p > right) ? p - right : right - p);
      if (g >= 135) return 8'd255;
      if (g >= int'(thr_shadow)) return 8'(g + 120);
      return p;
   endfunction

   // Finishes one pixel; rows of the directed table may pin the expected value.
   function automatic void finish_pixel(bit [7:0] p, int slot, bit [7:0] right,
                                        bit rl, bit fl);
      bit [7:0]   below;
      result_type r;
      below = at_frame_top ? p : line_buf[slot];
      line_buf[slot] = p;
      if (slot + 1 > line_filled) line_filled = slot + 1;
      r.pixel      = sharpen_value(p, below, right);
      r.row_last   = rl;
      r.frame_last = fl;
      if (done_pixels < NumDirected && dir_rows[done_pixels].typed) begin
         r.pixel      = dir_rows[done_pixels].exp_pix;
         r.row_last   = dir_rows[done_pixels].exp_rl;
         r.frame_last = dir_rows[done_pixels].exp_fl;
      end
      done_pixels++;
      sharpened_q.push_back(r);
   endfunction

   function automatic void predict_sharpened(bit [7:0] pix, bit rend, bit fend);
      if (held_ok) begin
         finish_pixel(held_pix, (col_cnt + LineSlots - 1) % LineSlots, pix, 1'b0, 1'b0);
         held_ok = 1'b0;
      end
      if (rend || fend) begin
         finish_pixel(pix, col_cnt, pix, 1'b1, fend);
         col_cnt      = 0;
         at_frame_top = fend;
      end else begin
         held_pix = pix;
         held_ok  = 1'b1;
         col_cnt  = (col_cnt + 1) % LineSlots;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) predict_sharpened(req_tdata, req_tlast, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (sharpened_q.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: pixel %0d last %0b frame %0b",
                           rsp_tdata, rsp_tlast, rsp_tuser[0]);
               mismatches++;
            end else begin
               want = sharpened_q.pop_front();
               if (rsp_tdata !== want.pixel || rsp_tlast !== want.row_last ||
                   rsp_tuser[0] !== want.frame_last) begin
                  if (mismatches < 10)
                     $display("mismatch: pixel %0d/%0d last %0b/%0b frame %0b/%0b (exp/act)",
                              want.pixel, rsp_tdata, want.row_last, rsp_tlast,
                              want.frame_last, rsp_tuser[0]);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_stall);

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_item(input bit [7:0] pix, input bit rend, input bit fend);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pix;
      req_tlast  = rend;
      req_tuser  = fend;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic drain_results();
      req_tvalid = 1'b0;
      while (sharpened_q.size() != 0) @(negedge clock);
   endtask

   task automatic set_threshold(input bit [7:0] value);
      drain_results();
      repeat (SettleCycles) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      thr_shadow  = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Ends any open row and frame so that no pixel is held.
   task automatic close_frame();
      if (col_cnt != 0 || !at_frame_top) send_item(8'($urandom_range(255)), 1'b1, 1'b1);
   endtask

   function automatic bit [7:0] pick_pixel(bit [7:0] prev);
      int v;
      case ($urandom_range(9))
         0: v = 0;
         1: v = 255;
         2, 3, 4, 5: begin
            v = int'(prev) + int'($urandom_range(60)) - 30;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         default: v = $urandom_range(255);
      endcase
      return 8'(v);
   endfunction

   task automatic run_random(input int count);
      int       stop_at;
      int       rows;
      int       width;
      bit       rend;
      bit       fend;
      bit [7:0] pix;
      stop_at = items_sent + count;
      pix     = 8'd128;
      while (items_sent < stop_at) begin
         rows = $urandom_range(1, 4);
         for (int r = 0; r < rows; r++) begin
            width = ($urandom_range(9) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
            for (int i = 0; i < width; i++) begin
               pix  = pick_pixel(pix);
               rend = (i == width - 1);
               fend = rend && (r == rows - 1);
               if ($urandom_range(24) == 0) {rend, fend} = 2'($urandom_range(3));
               // never read a line-buffer column that no row has written yet
               if (!at_frame_top && line_filled < LineSlots && col_cnt + 1 >= line_filled)
                  rend = 1'b1;
               send_item(pix, rend, fend);
            end
         end
         if ($urandom_range(11) == 0) drain_results();
      end
      close_frame();
   endtask

   initial begin
      dir_rows = '{
         // extremes in a one-row frame
         '{8'd0,   1'b0, 1'b0, 1'b1, 8'd255, 1'b0, 1'b0},
         '{8'd255, 1'b0, 1'b0, 1'b1, 8'd255, 1'b0, 1'b0},
         '{8'd0,   1'b1, 1'b1, 1'b1, 8'd0,   1'b1, 1'b1},
         // one-pixel frame
         '{8'd200, 1'b1, 1'b1, 1'b1, 8'd200, 1'b1, 1'b1},
         // g equal to threshold; second row ends the frame without tlast
         '{8'd10,  1'b0, 1'b0, 1'b1, 8'd150, 1'b0, 1'b0},
         '{8'd40,  1'b1, 1'b0, 1'b1, 8'd40,  1'b1, 1'b0},
         '{8'd10,  1'b0, 1'b0, 1'b1, 8'd10,  1'b0, 1'b0},
         '{8'd12,  1'b0, 1'b1, 1'b1, 8'd12,  1'b1, 1'b1},
         // both sides of the saturation limit
         '{8'd0,   1'b0, 1'b0, 1'b1, 8'd254, 1'b0, 1'b0},
         '{8'd134, 1'b0, 1'b0, 1'b1, 8'd254, 1'b0, 1'b0},
         '{8'd0,   1'b0, 1'b0, 1'b1, 8'd255, 1'b0, 1'b0},
         '{8'd135, 1'b1, 1'b1, 1'b1, 8'd135, 1'b1, 1'b1},
         // one below threshold, then a row left to the model
         '{8'd50,  1'b0, 1'b0, 1'b1, 8'd50,  1'b0, 1'b0},
         '{8'd79,  1'b1, 1'b0, 1'b1, 8'd79,  1'b1, 1'b0},
         '{8'd255, 1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
         '{8'd0,   1'b0, 1'b0, 1'b0, 8'd0,   1'b0, 1'b0},
         '{8'd255, 1'b1, 1'b1, 1'b0, 8'd0,   1'b0, 1'b0}
      };
      line_filled  = 0;
      held_ok      = 1'b0;
      col_cnt      = 0;
      at_frame_top = 1'b1;
      thr_shadow   = ThresholdReset;
      done_pixels  = 0;
      mismatches   = 0;
      items_sent   = 0;
      send_idle    = 0;
      recv_stall   = 0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[k]) send_item(dir_rows[k].pix, dir_rows[k].rend, dir_rows[k].fend);

      set_threshold(8'd0);
      run_random(PhaseItems);

      set_threshold(8'd255);
      send_idle = 70;
      run_random(PhaseItems);

      set_threshold(8'($urandom_range(1, 134)));
      send_idle  = 0;
      recv_stall = 70;
      run_random(PhaseItems);

      set_threshold(8'($urandom_range(1, 254)));
      send_idle  = 38;
      recv_stall = 38;
      run_random(PhaseItems);

      drain_results();
      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0 && sharpened_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/gst_pkg.sv
rtl/gst_line_buffer.sv
rtl/gst_result_fifo.sv
rtl/gradient_sharpen_threshold_top.sv
rtl/gst_checker.sv
sim/testbench.sv
